// ----- hdl/gcb_pkg.sv -----
package gcb_pkg;

    localparam int unsigned DATA_W    = 8;
    localparam int unsigned OFFSET_W  = 32;
    localparam int unsigned LENGTH_W  = 16;
    localparam int unsigned HASH_W    = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 32;
    localparam int unsigned GEAR_DEPTH = 256;

    localparam int unsigned FIFO_DEPTH = 2;

    localparam logic [LENGTH_W-1:0] MIN_CHUNK_RST     = 16'd1024;
    localparam logic [LENGTH_W-1:0] MAX_CHUNK_RST     = 16'd16384;
    localparam logic [HASH_W-1:0]   BOUNDARY_MASK_RST = 32'h0000_0FFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CHUNK     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHUNK     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_MASK = 2'd2;

    localparam logic [63:0] GEAR_SEED = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] GEAR_MULT = 64'h2545_F491_4F6C_DD1D;
    localparam int unsigned XS_SHIFT_A = 12;
    localparam int unsigned XS_SHIFT_B = 25;
    localparam int unsigned XS_SHIFT_C = 27;

    typedef logic [HASH_W-1:0] gear_table_t [GEAR_DEPTH];

    typedef struct packed {
        logic [LENGTH_W-1:0] min_chunk;
        logic [LENGTH_W-1:0] max_chunk;
        logic [HASH_W-1:0]   boundary_mask;
    } cfg_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] chunk_offset;
        logic [LENGTH_W-1:0] chunk_length;
        logic                final_chunk;
        logic                last_of_run;
    } chunk_t;

    // results of one byte: first always valid, second only when two is set
    typedef struct packed {
        chunk_t first;
        chunk_t second;
        logic   two;
    } chunk_pair_t;

    // xorshift-multiply generator, evaluated at elaboration
    function automatic gear_table_t gen_gear();
        logic [63:0] x;
        logic [63:0] idx;
        gear_table_t t;
        x = GEAR_SEED;
        for (int i = 0; i < GEAR_DEPTH; i++) begin
            x = x ^ (x >> XS_SHIFT_A);
            x = x ^ (x << XS_SHIFT_B);
            x = x ^ (x >> XS_SHIFT_C);
            x = x * GEAR_MULT;
            idx = 64'(i);
            t[i] = HASH_W'(x + idx * GEAR_SEED);
        end
        return t;
    endfunction

    localparam gear_table_t GEAR_ROM = gen_gear();

endpackage

// ----- hdl/gcb_if.sv -----
interface gcb_byte_if
    import gcb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              end_of_stream;

    modport source (output valid, data_byte, end_of_stream, input ready);
    modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface

interface gcb_chunk_if
    import gcb_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] chunk_offset;
    logic [LENGTH_W-1:0] chunk_length;
    logic                final_chunk;
    logic                last_of_run;

    modport source (output valid, chunk_offset, chunk_length, final_chunk, last_of_run,
                    input ready);
    modport sink   (input valid, chunk_offset, chunk_length, final_chunk, last_of_run,
                    output ready);
endinterface

interface gcb_cfg_if
    import gcb_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/gear_chunk_boundary_finder.sv -----
// A byte accepted at the input is held in the input register; its results
// are then written into the result queue and offered on the output from it.
// Throughput: one byte per cycle while the result queue is not full; the gear
// lookup, shift-add and cut compare sit between the input register and the
// result queue. Reset (rst_n, asynchronous, active low) clears hash, offsets
// and queue and loads min_chunk 1024, max_chunk 16384, boundary_mask 0xFFF.
module gear_chunk_boundary_finder
    import gcb_pkg::*;
#(
    parameter int unsigned OUT_DEPTH = FIFO_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    gcb_byte_if.sink   data_in,
    gcb_chunk_if.source chunk_out,
    gcb_cfg_if.sink    cfg
);

    cfg_t              cfg_reg, cfg_next;
    logic              in_valid_reg, in_valid_next;
    logic [DATA_W-1:0] in_byte_reg;
    logic              in_eos_reg;
    logic              in_fire;
    logic              advance;
    logic              fifo_full;
    logic              push;
    chunk_pair_t       push_data;

    assign cfg.ready     = 1'b1;
    assign advance       = in_valid_reg && !fifo_full;
    assign data_in.ready = !in_valid_reg || !fifo_full;
    assign in_fire       = data_in.valid && data_in.ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_MIN_CHUNK:     cfg_next.min_chunk     = cfg.data[LENGTH_W-1:0];
                REG_MAX_CHUNK:     cfg_next.max_chunk     = cfg.data[LENGTH_W-1:0];
                REG_BOUNDARY_MASK: cfg_next.boundary_mask = cfg.data[HASH_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_chunk     <= MIN_CHUNK_RST;
            cfg_reg.max_chunk     <= MAX_CHUNK_RST;
            cfg_reg.boundary_mask <= BOUNDARY_MASK_RST;
            in_valid_reg          <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            in_valid_reg <= in_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= data_in.data_byte;
            in_eos_reg  <= data_in.end_of_stream;
        end
    end

    gcb_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .data_byte     (in_byte_reg),
        .end_of_stream (in_eos_reg),
        .cfg           (cfg_reg),
        .push          (push),
        .push_data     (push_data)
    );

    gcb_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .chunk_out (chunk_out)
    );

endmodule

// ----- hdl/gcb_core.sv -----
module gcb_core
    import gcb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [DATA_W-1:0] data_byte,
    input  logic              end_of_stream,
    input  cfg_t              cfg,
    output logic              push,
    output chunk_pair_t       push_data
);

    logic [HASH_W-1:0]   hash_reg,  hash_next;
    logic [OFFSET_W-1:0] start_reg, start_next;
    logic [OFFSET_W-1:0] pos_reg,   pos_next;
    logic [LENGTH_W-1:0] len_reg,   len_next;

    logic                do_cut;
    logic [HASH_W-1:0]   hash_base;
    logic [HASH_W-1:0]   hash_absorb;
    logic [OFFSET_W-1:0] start_cut;
    logic [LENGTH_W-1:0] len_absorb;
    chunk_t              cut_chunk;
    chunk_t              final_chunk;

    always_comb
    begin
        do_cut = (len_reg != '0) &&
                 ((len_reg >= cfg.max_chunk) ||
                  ((len_reg >= cfg.min_chunk) && ((hash_reg & cfg.boundary_mask) == '0)));

        hash_base   = do_cut ? '0 : hash_reg;
        start_cut   = do_cut ? pos_reg : start_reg;
        // an open chunk is cut once its length reaches max_chunk, so this cannot wrap
        len_absorb  = (do_cut ? '0 : len_reg) + LENGTH_W'(1);
        hash_absorb = {hash_base[HASH_W-2:0], 1'b0} + GEAR_ROM[data_byte];

        cut_chunk.chunk_offset   = start_reg;
        cut_chunk.chunk_length   = len_reg;
        cut_chunk.final_chunk    = 1'b0;
        cut_chunk.last_of_run    = !end_of_stream;

        final_chunk.chunk_offset = start_cut;
        final_chunk.chunk_length = len_absorb;
        final_chunk.final_chunk  = 1'b1;
        final_chunk.last_of_run  = 1'b1;
    end

    always_comb
    begin
        push_data.first  = do_cut ? cut_chunk : final_chunk;
        push_data.second = final_chunk;
        push_data.two    = do_cut && end_of_stream;
        push             = advance && (do_cut || end_of_stream);
    end

    always_comb
    begin
        hash_next  = hash_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        if (advance)
        begin
            if (end_of_stream)
            begin
                // restart counters for the next stream
                hash_next  = '0;
                start_next = '0;
                pos_next   = '0;
                len_next   = '0;
            end
            else
            begin
                hash_next  = hash_absorb;
                start_next = start_cut;
                pos_next   = pos_reg + OFFSET_W'(1);
                len_next   = len_absorb;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= '0;
            start_reg <= '0;
            pos_reg   <= '0;
            len_reg   <= '0;
        end
        else
        begin
            hash_reg  <= hash_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
        end
    end

    a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        advance && end_of_stream |=> pos_reg == '0 && len_reg == '0 && hash_reg == '0)
        else $error("counters not restarted after end of stream");

    a_open_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !end_of_stream |=> len_reg != '0)
        else $error("open chunk empty after absorbing a byte");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !end_of_stream |=> pos_reg == $past(pos_reg) + OFFSET_W'(1))
        else $error("stream position did not advance by one");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(pos_reg) && $stable(len_reg) && $stable(hash_reg))
        else $error("state changed without a byte");

endmodule

// ----- hdl/gcb_out_fifo.sv -----
module gcb_out_fifo
    import gcb_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  chunk_pair_t push_data,
    output logic        full,
    gcb_chunk_if.source chunk_out
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    chunk_pair_t         mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic                sub_reg,    sub_next;
    chunk_pair_t         head;
    chunk_t              head_chunk;
    logic                out_fire;
    logic                pop;

    always_comb
    begin
        head       = mem[rd_ptr_reg];
        head_chunk = sub_reg ? head.second : head.first;
        full       = (count_reg == CNT_FULL);
        out_fire   = chunk_out.valid && chunk_out.ready;
        // drop the entry once its last result has gone out
        pop        = out_fire && (sub_reg || !head.two);
    end

    assign chunk_out.valid        = (count_reg != '0);
    assign chunk_out.chunk_offset = head_chunk.chunk_offset;
    assign chunk_out.chunk_length = head_chunk.chunk_length;
    assign chunk_out.final_chunk  = head_chunk.final_chunk;
    assign chunk_out.last_of_run  = head_chunk.last_of_run;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        sub_next    = sub_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            sub_next    = 1'b0;
        end
        else if (out_fire)
        begin
            sub_next = 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top
    import gcb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_CAP      = 100;
    localparam int LONG_LEN       = 201;

    // index the block decodes to nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    gcb_byte_if  byte_ch ();
    gcb_chunk_if chunk_ch ();
    gcb_cfg_if   cfg_ch ();

    gear_chunk_boundary_finder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_in   (byte_ch),
        .chunk_out (chunk_ch),
        .cfg       (cfg_ch)
    );

    always #1 clk = ~clk;

    // chunk predictor state
    logic [HASH_W-1:0]   gear_tbl [GEAR_DEPTH];
    logic [HASH_W-1:0]   pred_hash;
    logic [OFFSET_W-1:0] pred_start;
    logic [OFFSET_W-1:0] pred_pos;
    cfg_t                pred_cfg;
    chunk_t              pending_chunks [$];
    chunk_t              want_c;

    int fail_count  = 0;
    int bytes_taken = 0;
    int chunks_seen = 0;
    int reg_writes  = 0;
    int stall_count = 0;

    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int rx_hold_cycles = 0;

    function automatic void build_gear_table();
        logic [63:0] x;
        x = GEAR_SEED;
        for (int i = 0; i < GEAR_DEPTH; i++) begin
            x = x ^ (x >> XS_SHIFT_A);
            x = x ^ (x << XS_SHIFT_B);
            x = x ^ (x >> XS_SHIFT_C);
            x = x * GEAR_MULT;
            gear_tbl[i] = HASH_W'(x + 64'(i) * GEAR_SEED);
        end
    endfunction

    task automatic absorb_byte(input logic [DATA_W-1:0] b, input logic eos);
        logic [OFFSET_W-1:0] len;
        logic                cut;
        chunk_t              c;
        len = pred_pos - pred_start;
        cut = (len >= pred_cfg.max_chunk) ||
              (len >= pred_cfg.min_chunk && (pred_hash & pred_cfg.boundary_mask) == '0);
        // never cut an empty chunk
        if (cut && len != '0) begin
            c.chunk_offset = pred_start;
            c.chunk_length = len[LENGTH_W-1:0];
            c.final_chunk  = 1'b0;
            c.last_of_run  = ~eos;
            pending_chunks.push_back(c);
            pred_start = pred_pos;
            pred_hash  = '0;
        end
        pred_hash = (pred_hash << 1) + gear_tbl[b];
        pred_pos  = pred_pos + 1;
        if (eos) begin
            len = pred_pos - pred_start;
            c.chunk_offset = pred_start;
            c.chunk_length = len[LENGTH_W-1:0];
            c.final_chunk  = 1'b1;
            c.last_of_run  = 1'b1;
            pending_chunks.push_back(c);
            pred_hash  = '0;
            pred_start = '0;
            pred_pos   = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PRINT_CAP)
            $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    // predict on accepted bytes and register writes, compare accepted chunks
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                reg_writes++;
                case (cfg_ch.index)
                    REG_MIN_CHUNK:     pred_cfg.min_chunk = cfg_ch.data[LENGTH_W-1:0];
                    REG_MAX_CHUNK:     pred_cfg.max_chunk = cfg_ch.data[LENGTH_W-1:0];
                    REG_BOUNDARY_MASK: pred_cfg.boundary_mask = cfg_ch.data[HASH_W-1:0];
                    default: ;
                endcase
            end
            if (byte_ch.valid && byte_ch.ready) begin
                bytes_taken++;
                absorb_byte(byte_ch.data_byte, byte_ch.end_of_stream);
            end
            if (chunk_ch.valid && chunk_ch.ready) begin
                chunks_seen++;
                if (pending_chunks.size() == 0) begin
                    report_mismatch("chunk with nothing expected", chunk_ch.chunk_offset, '0);
                end
                else begin
                    want_c = pending_chunks.pop_front();
                    check_field("chunk_offset", chunk_ch.chunk_offset, want_c.chunk_offset);
                    check_field("chunk_length", 32'(chunk_ch.chunk_length),
                                32'(want_c.chunk_length));
                    check_field("final_chunk", 32'(chunk_ch.final_chunk),
                                32'(want_c.final_chunk));
                    check_field("last_of_run", 32'(chunk_ch.last_of_run),
                                32'(want_c.last_of_run));
                end
            end
        end
    end

    // end the run when no transaction of any kind happens for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((byte_ch.valid && byte_ch.ready) || (chunk_ch.valid && chunk_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= WATCHDOG_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL gear_chunk_boundary_finder");
                $finish;
            end
        end
    end

    // result receiver: random stalls, plus a long hold-off on request
    initial begin : result_sink
        int w;
        chunk_ch.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                chunk_ch.ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            w = rx_quiet ? 0 : $urandom_range(0, 9);
            if (w > 0) begin
                chunk_ch.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            chunk_ch.ready <= 1'b1;
            do @(posedge clk);
            while (!(chunk_ch.valid && chunk_ch.ready) && rx_hold_cycles == 0);
        end
    end

    task automatic send_byte(input logic [DATA_W-1:0] b, input logic eos);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.data_byte     <= b;
        byte_ch.end_of_stream <= eos;
        do @(posedge clk);
        while (!(byte_ch.valid && byte_ch.ready));
    endtask

    // drop valid, wait for every expected chunk, then let the pipeline settle
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_chunks.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_stream(input int len);
        for (int k = 0; k < len; k++)
            send_byte(DATA_W'($urandom_range(0, 255)), k == len - 1);
    endtask

    // reset values: no cut before 1024 bytes, so one final chunk
    task automatic test_reset_defaults();
        send_stream(20);
        wait_drained();
    endtask

    // max zero and mask zero both give one-byte chunks, incl. a cut on the final byte; then min_chunk 3
    task automatic test_single_byte_chunks();
        write_reg(REG_MIN_CHUNK, 32'd0);
        write_reg(REG_MAX_CHUNK, 32'd0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b1);
        write_reg(REG_MAX_CHUNK, 32'd65535);
        write_reg(REG_BOUNDARY_MASK, 32'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b1);
        write_reg(REG_MIN_CHUNK, 32'd3);
        send_stream(9);
        wait_drained();
    endtask

    // forced cut at max_chunk right before the final byte, min_chunk at its top
    task automatic test_longest_chunk();
        write_reg(REG_MIN_CHUNK, 32'd65535);
        write_reg(REG_MAX_CHUNK, 32'(LONG_LEN - 1));
        write_reg(REG_BOUNDARY_MASK, 32'hFFFF_FFFF);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        send_stream(LONG_LEN);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        wait_drained();
    endtask

    // lower max below the open chunk's length; the next byte forces a cut
    task automatic test_config_mid_chunk();
        write_reg(REG_MIN_CHUNK, 32'd0);
        write_reg(REG_MAX_CHUNK, 32'd60000);
        write_reg(REG_BOUNDARY_MASK, 32'hFFFF_FFFF);
        for (int k = 0; k < 20; k++)
            send_byte(DATA_W'($urandom_range(0, 255)), 1'b0);
        write_reg(REG_MAX_CHUNK, 32'd6);
        write_reg(REG_UNUSED, $urandom);
        send_stream(8);
        wait_drained();
    endtask

    // hold the output off while bytes keep coming, so the input stalls
    task automatic test_output_backpressure();
        write_reg(REG_MIN_CHUNK, 32'd0);
        write_reg(REG_MAX_CHUNK, 32'd1);
        tx_quiet = 1'b1;
        rx_hold_cycles = HOLD_CYCLES;
        send_stream(40);
        tx_quiet = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_streams();
        int          sent;
        int          len;
        int unsigned pick;
        bit          open_end;
        logic [15:0] mn;
        logic [15:0] mx;
        logic [31:0] mk;
        sent = 0;
        open_end = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            mn = 16'($urandom_range(0, 12));
            mx = 16'($urandom_range(1, 48));
            if (pick == 0)
                mx = 16'd0;
            if (pick == 1)
                mn = 16'hFFFF;
            case ($urandom_range(0, 5))
                0:       mk = 32'd0;
                1:       mk = 32'd1;
                2:       mk = 32'd3;
                3:       mk = 32'd7;
                4:       mk = 32'hF;
                default: mk = $urandom;
            endcase
            write_reg(REG_MIN_CHUNK, 32'(mn));
            write_reg(REG_MAX_CHUNK, 32'(mx));
            write_reg(REG_BOUNDARY_MASK, mk);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            // now and then keep the stream open across the next settings
            open_end = ($urandom_range(0, 7) == 0);
            len = $urandom_range(1, 80);
            for (int k = 0; k < len; k++)
                send_byte(DATA_W'($urandom_range(0, 255)), (k == len - 1) && !open_end);
            sent += len;
        end
        if (open_end)
            send_byte(DATA_W'($urandom_range(0, 255)), 1'b1);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        wait_drained();
    endtask

    initial begin
        byte_ch.valid         <= 1'b0;
        byte_ch.data_byte     <= '0;
        byte_ch.end_of_stream <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= '0;
        cfg_ch.data           <= '0;
        build_gear_table();
        pred_hash  = '0;
        pred_start = '0;
        pred_pos   = '0;
        pred_cfg.min_chunk     = MIN_CHUNK_RST;
        pred_cfg.max_chunk     = MAX_CHUNK_RST;
        pred_cfg.boundary_mask = BOUNDARY_MASK_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_single_byte_chunks();
        test_longest_chunk();
        test_config_mid_chunk();
        test_output_backpressure();
        test_random_streams();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_chunks.size() != 0)
            report_mismatch("chunks never delivered", pending_chunks.size(), '0);

        $display("covered %0d bytes, %0d chunks, %0d register writes", bytes_taken,
                 chunks_seen, reg_writes);
        $display("defaults, one-byte chunks, forced cuts at max, mid-chunk changes, stalls");
        if (fail_count == 0)
            $display("PASS gear_chunk_boundary_finder");
        else
            $display("FAIL gear_chunk_boundary_finder");
        $finish;
    end

endmodule

// ----- gear_chunk_boundary_finder.f -----
hdl/gcb_pkg.sv
hdl/gcb_if.sv
hdl/gcb_core.sv
hdl/gcb_out_fifo.sv
hdl/gear_chunk_boundary_finder.sv
tb/tb_top.sv
